[design/lur_pkg.sv]
// Shared types, constants and fixed-point helpers of the lens undistortion remap core.
`timescale 1ns / 1ps

package lur_pkg;

    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;

    // quotient bits produced by the normalizing divider
    localparam int DIV_STEPS = 31;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [19:0] FOCAL_RST = 20'd163840;

    localparam logic signed [31:0] Q_ONE  = 32'sd1048576;
    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [63:0] W_QMAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] W_QMIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_PRINCIPAL = 3'd2,
        CFG_K1        = 3'd3,
        CFG_K2        = 3'd4,
        CFG_K3        = 3'd5,
        CFG_P1        = 3'd6,
        CFG_P2        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_func      func;
        logic [9:0] pos_x;
        logic [8:0] pos_y;
        logic [7:0] pixel;
    } t_meta;

    // fx/fy already have the zero case replaced by one
    typedef struct packed {
        logic [19:0] fx;
        logic [19:0] fy;
        logic [23:0] cx;
        logic [23:0] cy;
        logic [23:0] k1;
        logic [23:0] k2;
        logic [23:0] k3;
        logic [23:0] p1;
        logic [23:0] p2;
    } t_cfg;

    function automatic logic signed [31:0] q_sx24(input logic [23:0] v);
        return $signed({{8{v[23]}}, v});
    endfunction

    // Q.20 product: floor shift by 20, saturate to 32 bits
    function automatic logic signed [31:0] q_ss(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 20;
        if (s > W_QMAX) begin
            return Q_MAX;
        end else if (s < W_QMIN) begin
            return Q_MIN;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? Q_MIN : Q_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] q_dbl(input logic signed [31:0] a);
        return q_add(a, a);
    endfunction

endpackage

[design/lur_norm.sv]
// Pipelined normalizing divider: pixel coordinate minus centre, over focal length, Q.20.
`timescale 1ns / 1ps

module lur_norm import lur_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_meta              i_meta,
    input  t_cfg               i_cfg,
    output logic               o_vld,
    output t_meta              o_meta,
    output logic signed [31:0] o_xn,
    output logic signed [31:0] o_yn
);

    typedef struct packed {
        logic [19:0] rem;
        logic [30:0] d;     // dividend bits in, quotient bits out
        logic        ovf;
        logic        neg;
    } t_divst;

    function automatic t_divst div_prep(input logic [25:0] num, input logic [23:0] ctr,
                                        input logic [19:0] f);
        logic signed [25:0] diff;
        logic [23:0]        mag;
        t_divst             s;
        diff  = $signed(num) - $signed({2'b00, ctr});
        mag   = diff[25] ? 24'(-diff) : diff[23:0];
        s.neg = diff[25];
        // quotient would need 32 or more bits
        s.ovf = {7'b0, mag} >= {f, 11'b0};
        s.rem = {7'b0, mag[23:11]};
        s.d   = {mag[10:0], 20'b0};
        return s;
    endfunction

    function automatic t_divst div_step(input t_divst s, input logic [19:0] f);
        logic [20:0] t;
        logic        ge;
        t_divst      r;
        t     = {s.rem, s.d[30]};
        ge    = t >= {1'b0, f};
        r     = s;
        r.rem = ge ? 20'(t - {1'b0, f}) : t[19:0];
        r.d   = {s.d[29:0], ge};
        return r;
    endfunction

    function automatic logic signed [31:0] div_done(input t_divst s);
        logic signed [31:0] q;
        q = $signed({1'b0, s.d});
        if (s.ovf) begin
            return s.neg ? Q_MIN : Q_MAX;
        end
        return s.neg ? -q : q;
    endfunction

    t_divst             r_sx   [0:DIV_STEPS];
    t_divst             r_sy   [0:DIV_STEPS];
    logic               r_vld  [0:DIV_STEPS];
    t_meta              r_meta [0:DIV_STEPS];
    logic               r_out_vld;
    t_meta              r_out_meta;
    logic signed [31:0] r_xn;
    logic signed [31:0] r_yn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STEPS; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s <= DIV_STEPS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta[0] <= i_meta;
            r_sx[0]   <= div_prep({8'b0, i_meta.pos_x, 8'b0}, i_cfg.cx, i_cfg.fx);
            r_sy[0]   <= div_prep({9'b0, i_meta.pos_y, 8'b0}, i_cfg.cy, i_cfg.fy);
            for (int s = 1; s <= DIV_STEPS; s++) begin
                r_meta[s] <= r_meta[s-1];
                r_sx[s]   <= div_step(r_sx[s-1], i_cfg.fx);
                r_sy[s]   <= div_step(r_sy[s-1], i_cfg.fy);
            end
            r_out_meta <= r_meta[DIV_STEPS];
            r_xn       <= div_done(r_sx[DIV_STEPS]);
            r_yn       <= div_done(r_sy[DIV_STEPS]);
        end
    end

    assign o_vld  = r_out_vld;
    assign o_meta = r_out_meta;
    assign o_xn   = r_xn;
    assign o_yn   = r_yn;

endmodule

[design/lur_warp.sv]
// Distortion polynomial and mapping back to clamped source pixel coordinates.
`timescale 1ns / 1ps

module lur_warp import lur_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    localparam int XW = $clog2(FRAME_WIDTH),
    localparam int YW = $clog2(FRAME_HEIGHT)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_meta              i_meta,
    input  t_cfg               i_cfg,
    input  logic signed [31:0] i_xn,
    input  logic signed [31:0] i_yn,
    output logic               o_vld,
    output t_meta              o_meta,
    output logic [XW-1:0]      o_x0,
    output logic [YW-1:0]      o_y0,
    output logic [7:0]         o_dx,
    output logic [7:0]         o_dy
);

    localparam int NST = 12;
    localparam logic signed [33:0] X_LIM = 34'((FRAME_WIDTH - 1) * 256);
    localparam logic signed [33:0] Y_LIM = 34'((FRAME_HEIGHT - 1) * 256);
    localparam logic [XW+7:0] X_TOP = (XW+8)'((FRAME_WIDTH - 2) * 256);
    localparam logic [YW+7:0] Y_TOP = (YW+8)'((FRAME_HEIGHT - 2) * 256);

    logic  r_vld  [0:NST-1];
    t_meta r_meta [0:NST-1];

    // stage n registers carry prefix rn_
    logic signed [31:0] r1_xn, r1_yn;
    logic signed [63:0] r1_pxx, r1_pyy, r1_pxy;
    logic signed [31:0] r2_xn, r2_yn, r2_xx, r2_yy, r2_xy, r2_r2;
    logic signed [31:0] r3_xn, r3_yn, r3_r2, r3_a2x, r3_a2y;
    logic signed [63:0] r3_pr4, r3_pk1, r3_pp1, r3_pp2;
    logic signed [31:0] r4_xn, r4_yn, r4_r2, r4_a2x, r4_a2y, r4_r4, r4_rad, r4_t1x, r4_t2y;
    logic signed [31:0] r5_xn, r5_yn, r5_rad, r5_t1x, r5_t2y;
    logic signed [63:0] r5_pr6, r5_pk2, r5_ptx, r5_pty;
    logic signed [31:0] r6_xn, r6_yn, r6_r6, r6_rad, r6_tx, r6_ty;
    logic signed [31:0] r7_xn, r7_yn, r7_rad, r7_tx, r7_ty;
    logic signed [63:0] r7_pk3;
    logic signed [31:0] r8_xn, r8_yn, r8_rad, r8_tx, r8_ty;
    logic signed [63:0] r9_pxr, r9_pyr;
    logic signed [31:0] r9_tx, r9_ty;
    logic signed [31:0] r10_xd, r10_yd;
    logic signed [52:0] r11_pxf, r11_pyf;
    logic [XW-1:0]      r12_x0;
    logic [YW-1:0]      r12_y0;
    logic [7:0]         r12_dx, r12_dy;

    logic signed [33:0] w_sx, w_sy;
    logic [XW+7:0]      w_cx;
    logic [YW+7:0]      w_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < NST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // source point in Q.8 and clamp into the frame
    always_comb begin
        w_sx = 34'(r11_pxf >>> 20) + $signed({10'b0, i_cfg.cx});
        w_sy = 34'(r11_pyf >>> 20) + $signed({10'b0, i_cfg.cy});
        if (w_sx < 0) begin
            w_cx = '0;
        end else if (w_sx >= X_LIM) begin
            w_cx = X_TOP;
        end else begin
            w_cx = w_sx[XW+7:0];
        end
        if (w_sy < 0) begin
            w_cy = '0;
        end else if (w_sy >= Y_LIM) begin
            w_cy = Y_TOP;
        end else begin
            w_cy = w_sy[YW+7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta[0] <= i_meta;
            for (int s = 1; s < NST; s++) begin
                r_meta[s] <= r_meta[s-1];
            end

            r1_xn  <= i_xn;
            r1_yn  <= i_yn;
            r1_pxx <= i_xn * i_xn;
            r1_pyy <= i_yn * i_yn;
            r1_pxy <= i_xn * i_yn;

            r2_xn <= r1_xn;
            r2_yn <= r1_yn;
            r2_xx <= q_ss(r1_pxx);
            r2_yy <= q_ss(r1_pyy);
            r2_xy <= q_ss(r1_pxy);
            r2_r2 <= q_add(q_ss(r1_pxx), q_ss(r1_pyy));

            r3_xn  <= r2_xn;
            r3_yn  <= r2_yn;
            r3_r2  <= r2_r2;
            r3_pr4 <= r2_r2 * r2_r2;
            r3_pk1 <= q_sx24(i_cfg.k1) * r2_r2;
            r3_pp1 <= q_sx24(i_cfg.p1) * r2_xy;
            r3_pp2 <= q_sx24(i_cfg.p2) * r2_xy;
            r3_a2x <= q_add(r2_r2, q_dbl(r2_xx));
            r3_a2y <= q_add(r2_r2, q_dbl(r2_yy));

            r4_xn  <= r3_xn;
            r4_yn  <= r3_yn;
            r4_r2  <= r3_r2;
            r4_a2x <= r3_a2x;
            r4_a2y <= r3_a2y;
            r4_r4  <= q_ss(r3_pr4);
            r4_rad <= q_add(Q_ONE, q_ss(r3_pk1));
            r4_t1x <= q_dbl(q_ss(r3_pp1));
            r4_t2y <= q_dbl(q_ss(r3_pp2));

            r5_xn  <= r4_xn;
            r5_yn  <= r4_yn;
            r5_rad <= r4_rad;
            r5_t1x <= r4_t1x;
            r5_t2y <= r4_t2y;
            r5_pr6 <= r4_r4 * r4_r2;
            r5_pk2 <= q_sx24(i_cfg.k2) * r4_r4;
            r5_ptx <= q_sx24(i_cfg.p2) * r4_a2x;
            r5_pty <= q_sx24(i_cfg.p1) * r4_a2y;

            r6_xn  <= r5_xn;
            r6_yn  <= r5_yn;
            r6_r6  <= q_ss(r5_pr6);
            r6_rad <= q_add(r5_rad, q_ss(r5_pk2));
            r6_tx  <= q_add(r5_t1x, q_ss(r5_ptx));
            r6_ty  <= q_add(q_ss(r5_pty), r5_t2y);

            r7_xn  <= r6_xn;
            r7_yn  <= r6_yn;
            r7_rad <= r6_rad;
            r7_tx  <= r6_tx;
            r7_ty  <= r6_ty;
            r7_pk3 <= q_sx24(i_cfg.k3) * r6_r6;

            r8_xn  <= r7_xn;
            r8_yn  <= r7_yn;
            r8_tx  <= r7_tx;
            r8_ty  <= r7_ty;
            r8_rad <= q_add(r7_rad, q_ss(r7_pk3));

            r9_tx  <= r8_tx;
            r9_ty  <= r8_ty;
            r9_pxr <= r8_xn * r8_rad;
            r9_pyr <= r8_yn * r8_rad;

            r10_xd <= q_add(q_ss(r9_pxr), r9_tx);
            r10_yd <= q_add(q_ss(r9_pyr), r9_ty);

            r11_pxf <= r10_xd * $signed({1'b0, i_cfg.fx});
            r11_pyf <= r10_yd * $signed({1'b0, i_cfg.fy});

            // a load carries its own write position on
            if (r_meta[10].func == FUNC_LOAD) begin
                r12_x0 <= XW'(r_meta[10].pos_x);
                r12_y0 <= YW'(r_meta[10].pos_y);
                r12_dx <= '0;
                r12_dy <= '0;
            end else begin
                r12_x0 <= w_cx[XW+7:8];
                r12_y0 <= w_cy[YW+7:8];
                r12_dx <= w_cx[7:0];
                r12_dy <= w_cy[7:0];
            end
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_meta = r_meta[NST-1];
    assign o_x0   = r12_x0;
    assign o_y0   = r12_y0;
    assign o_dx   = r12_dx;
    assign o_dy   = r12_dy;

endmodule

[design/lur_fetch.sv]
// Four-bank frame store, pixel fetch and bilinear blend.
`timescale 1ns / 1ps

module lur_fetch import lur_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
    localparam int XW = $clog2(FRAME_WIDTH),
    localparam int YW = $clog2(FRAME_HEIGHT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  t_meta         i_meta,
    input  logic [XW-1:0] i_x0,
    input  logic [YW-1:0] i_y0,
    input  logic [7:0]    i_dx,
    input  logic [7:0]    i_dy,
    output logic          o_res_vld,
    output logic [7:0]    o_pixel
);

    // banks split by column and row parity
    localparam int HALF_W     = (FRAME_WIDTH + 1) / 2;
    localparam int HALF_H     = (FRAME_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int AW         = $clog2(BANK_DEPTH);

    logic [XW:0]   w_x1;
    logic [YW:0]   w_y1;
    logic          w_in_frame;

    // F1
    logic          r1_smp, r1_we;
    logic [1:0]    r1_wbank;
    logic [7:0]    r1_wdata;
    logic [AW-1:0] r1_rb [0:1];
    logic [XW-1:0] r1_hx [0:1];
    logic          r1_xp, r1_yp;
    logic [16:0]   r1_w  [0:3];
    // F2
    logic          r2_smp, r2_we;
    logic [1:0]    r2_wbank;
    logic [7:0]    r2_wdata;
    logic [AW-1:0] r2_addr [0:3];
    logic          r2_xp, r2_yp;
    logic [16:0]   r2_w  [0:3];
    // F3
    logic          r3_smp;
    logic [7:0]    r3_rd [0:3];
    logic          r3_xp, r3_yp;
    logic [16:0]   r3_w  [0:3];
    // F4
    logic          r4_smp;
    logic [24:0]   r4_prod [0:3];
    // F5
    logic          r5_vld;
    logic [7:0]    r5_pix;

    logic [7:0]    w_pix [0:3];
    logic [25:0]   w_sum;

    assign w_x1       = {1'b0, i_x0} + 1'b1;
    assign w_y1       = {1'b0, i_y0} + 1'b1;
    assign w_in_frame = (13'(i_meta.pos_x) < 13'(FRAME_WIDTH))
                      && (13'(i_meta.pos_y) < 13'(FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_smp <= 1'b0;
            r1_we  <= 1'b0;
            r2_smp <= 1'b0;
            r2_we  <= 1'b0;
            r3_smp <= 1'b0;
            r4_smp <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_smp <= i_vld && (i_meta.func == FUNC_SAMPLE);
            r1_we  <= i_vld && (i_meta.func == FUNC_LOAD) && w_in_frame;
            r2_smp <= r1_smp;
            r2_we  <= r1_we;
            r3_smp <= r2_smp;
            r4_smp <= r3_smp;
            r5_vld <= r4_smp;
        end
    end

    // F1: half indexes, row bases, weights
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_wbank <= {i_y0[0], i_x0[0]};
            r1_wdata <= i_meta.pixel;
            r1_xp    <= i_x0[0];
            r1_yp    <= i_y0[0];
            r1_hx[0] <= w_x1[XW:1];
            r1_hx[1] <= {1'b0, i_x0[XW-1:1]};
            r1_rb[0] <= AW'(w_y1[YW:1] * HALF_W);
            r1_rb[1] <= AW'({1'b0, i_y0[YW-1:1]} * HALF_W);
            r1_w[0]  <= (9'd256 - {1'b0, i_dx}) * (9'd256 - {1'b0, i_dy});
            r1_w[1]  <= {1'b0, i_dx} * (9'd256 - {1'b0, i_dy});
            r1_w[2]  <= (9'd256 - {1'b0, i_dx}) * {1'b0, i_dy};
            r1_w[3]  <= {1'b0, i_dx} * {1'b0, i_dy};
        end
    end

    // F2: bank address = row base of its row parity + half column of its column parity
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_wbank <= r1_wbank;
            r2_wdata <= r1_wdata;
            r2_xp    <= r1_xp;
            r2_yp    <= r1_yp;
            for (int b = 0; b < 4; b++) begin
                r2_addr[b] <= AW'({1'b0, r1_rb[b/2]} + (AW+1)'(r1_hx[b%2]));
                r2_w[b]    <= r1_w[b];
            end
        end
    end

    // F3: store banks, one write and one registered read each
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] r_mem [0:BANK_DEPTH-1];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r2_we && (r2_wbank == 2'(b))) begin
                    r_mem[r2_addr[b]] <= r2_wdata;
                end
                r3_rd[b] <= r_mem[r2_addr[b]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_xp <= r2_xp;
            r3_yp <= r2_yp;
            for (int b = 0; b < 4; b++) begin
                r3_w[b] <= r2_w[b];
            end
        end
    end

    // F4: route banks to corners, weight them
    always_comb begin
        w_pix[0] = r3_rd[{r3_yp, r3_xp}];
        w_pix[1] = r3_rd[{r3_yp, ~r3_xp}];
        w_pix[2] = r3_rd[{~r3_yp, r3_xp}];
        w_pix[3] = r3_rd[{~r3_yp, ~r3_xp}];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int b = 0; b < 4; b++) begin
                r4_prod[b] <= r3_w[b] * w_pix[b];
            end
        end
    end

    // F5: blend and truncate
    assign w_sum = 26'(r4_prod[0]) + 26'(r4_prod[1]) + 26'(r4_prod[2]) + 26'(r4_prod[3]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_pix <= w_sum[23:16];
        end
    end

    assign o_res_vld = r5_vld;
    assign o_pixel   = r5_pix;

endmodule

[design/lens_undistort_remap_core.sv]
// Top level of the lens undistortion remap core: config registers, pipeline, output register.
`timescale 1ns / 1ps

// channel  direction  handshake                   word
// in       sink       i_in_valid / o_in_ready     i_func, i_pos_x, i_pos_y, i_pixel_in
// out      source     o_out_valid / i_out_ready   o_pixel_out
// cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One word per clock on the in channel while o_in_ready is high. A sample word passes the
// divider (31 quotient bits, one per stage), the distortion pipeline, fetch and blend, and
// the output register. Load words write the frame store from inside the pipeline, in order
// with samples. Reset clears valid bits, zeroes the principal point and coefficients and
// sets both focal lengths to FOCAL_RST; the frame store keeps its contents.
// The pipeline holds only when its last stage carries a result that the full output
// register cannot take; bubbles behind a waiting result stay where they are.

module lens_undistort_remap_core import lur_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [9:0]            i_pos_x,
    input  logic [8:0]            i_pos_y,
    input  logic [7:0]            i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_pixel_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int XW = $clog2(FRAME_WIDTH);
    localparam int YW = $clog2(FRAME_HEIGHT);

    // config registers
    logic [19:0] r_focal_x, r_focal_y;
    logic [47:0] r_principal;
    logic [23:0] r_k1, r_k2, r_k3, r_p1, r_p2;
    t_cfg        w_cfg;

    // pipeline links
    logic               w_en;
    logic               w_take;
    t_meta              w_in_meta;
    logic               w_n_vld;
    t_meta              w_n_meta;
    logic signed [31:0] w_xn, w_yn;
    logic               w_w_vld;
    t_meta              w_w_meta;
    logic [XW-1:0]      w_x0;
    logic [YW-1:0]      w_y0;
    logic [7:0]         w_dx, w_dy;
    logic               w_res_vld;
    logic [7:0]         w_res_pix;

    // output register
    logic       r_out_vld;
    logic [7:0] r_out_pix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x   <= FOCAL_RST;
            r_focal_y   <= FOCAL_RST;
            r_principal <= '0;
            r_k1        <= '0;
            r_k2        <= '0;
            r_k3        <= '0;
            r_p1        <= '0;
            r_p2        <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL_X:   r_focal_x   <= i_cfg_data[19:0];
                CFG_FOCAL_Y:   r_focal_y   <= i_cfg_data[19:0];
                CFG_PRINCIPAL: r_principal <= i_cfg_data[47:0];
                CFG_K1:        r_k1        <= i_cfg_data[23:0];
                CFG_K2:        r_k2        <= i_cfg_data[23:0];
                CFG_K3:        r_k3        <= i_cfg_data[23:0];
                CFG_P1:        r_p1        <= i_cfg_data[23:0];
                CFG_P2:        r_p2        <= i_cfg_data[23:0];
                default:       ;
            endcase
        end
    end

    // a zero focal length acts as 1/256 pixel
    always_comb begin
        w_cfg.fx = (r_focal_x == '0) ? 20'd1 : r_focal_x;
        w_cfg.fy = (r_focal_y == '0) ? 20'd1 : r_focal_y;
        w_cfg.cx = r_principal[47:24];
        w_cfg.cy = r_principal[23:0];
        w_cfg.k1 = r_k1;
        w_cfg.k2 = r_k2;
        w_cfg.k3 = r_k3;
        w_cfg.p1 = r_p1;
        w_cfg.p2 = r_p2;
    end

    // whole pipeline steps together; it waits only on a stuck result
    assign w_take     = w_res_vld && (!r_out_vld || i_out_ready);
    assign w_en       = !w_res_vld || w_take;
    assign o_in_ready = w_en;

    assign w_in_meta.func  = t_func'(i_func);
    assign w_in_meta.pos_x = i_pos_x;
    assign w_in_meta.pos_y = i_pos_y;
    assign w_in_meta.pixel = i_pixel_in;

    lur_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_meta  (w_in_meta),
        .i_cfg   (w_cfg),
        .o_vld   (w_n_vld),
        .o_meta  (w_n_meta),
        .o_xn    (w_xn),
        .o_yn    (w_yn)
    );

    lur_warp #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_warp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_n_vld),
        .i_meta  (w_n_meta),
        .i_cfg   (w_cfg),
        .i_xn    (w_xn),
        .i_yn    (w_yn),
        .o_vld   (w_w_vld),
        .o_meta  (w_w_meta),
        .o_x0    (w_x0),
        .o_y0    (w_y0),
        .o_dx    (w_dx),
        .o_dy    (w_dy)
    );

    lur_fetch #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_fetch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (w_w_vld),
        .i_meta    (w_w_meta),
        .i_x0      (w_x0),
        .i_y0      (w_y0),
        .i_dx      (w_dx),
        .i_dy      (w_dy),
        .o_res_vld (w_res_vld),
        .o_pixel   (w_res_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || i_out_ready) begin
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_pix <= w_res_pix;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pixel_out = r_out_pix;

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the lens undistortion remap core.
`timescale 1ns / 1ps

// Scoreboard: own copy of the lens model, frame store and expected pixel queue.
class remap_scoreboard;
    logic [19:0] fx_reg, fy_reg;
    logic [47:0] pp_reg;
    logic [23:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
    byte unsigned frame_pix [0:307199];
    bit frame_valid [0:307199];
    byte unsigned expected_pixels [$];
    int mismatches;

    function new();
        fx_reg = 20'd163840;
        fy_reg = 20'd163840;
        pp_reg = '0;
        {k1_reg, k2_reg, k3_reg, p1_reg, p2_reg} = '0;
        mismatches = 0;
    endfunction

    function void set_reg(lur_pkg::t_cfg_idx idx, logic [47:0] data);
        case (idx)
            lur_pkg::CFG_FOCAL_X:   fx_reg = data[19:0];
            lur_pkg::CFG_FOCAL_Y:   fy_reg = data[19:0];
            lur_pkg::CFG_PRINCIPAL: pp_reg = data;
            lur_pkg::CFG_K1:        k1_reg = data[23:0];
            lur_pkg::CFG_K2:        k2_reg = data[23:0];
            lur_pkg::CFG_K3:        k3_reg = data[23:0];
            lur_pkg::CFG_P1:        p1_reg = data[23:0];
            lur_pkg::CFG_P2:        p2_reg = data[23:0];
            default: ;
        endcase
    endfunction

    function longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint qm(longint a, longint b);
        return sat((a * b) >>> 20);
    endfunction

    function longint qa(longint a, longint b);
        return sat(a + b);
    endfunction

    // Source point in Q.8, clamped into the frame
    function void locate(int px, int py, output longint sx, output longint sy);
        longint fx, fy, cx, cy, k1, k2, k3, p1, p2;
        longint xn, yn, xx, yy, xy, r2, r4, r6, rad, tx, ty, xd, yd;
        fx = (fx_reg == 0) ? 1 : fx_reg;
        fy = (fy_reg == 0) ? 1 : fy_reg;
        cx = pp_reg[47:24];
        cy = pp_reg[23:0];
        k1 = $signed(k1_reg);
        k2 = $signed(k2_reg);
        k3 = $signed(k3_reg);
        p1 = $signed(p1_reg);
        p2 = $signed(p2_reg);
        xn = sat(((longint'(px) * 256 - cx) * 64'sd1048576) / fx);
        yn = sat(((longint'(py) * 256 - cy) * 64'sd1048576) / fy);
        xx = qm(xn, xn);
        yy = qm(yn, yn);
        xy = qm(xn, yn);
        r2 = qa(xx, yy);
        r4 = qm(r2, r2);
        r6 = qm(r4, r2);
        rad = qa(64'sd1048576, qm(k1, r2));
        rad = qa(rad, qm(k2, r4));
        rad = qa(rad, qm(k3, r6));
        tx = qa(sat(2 * qm(p1, xy)), qm(p2, qa(r2, sat(2 * xx))));
        ty = qa(qm(p1, qa(r2, sat(2 * yy))), sat(2 * qm(p2, xy)));
        xd = qa(qm(xn, rad), tx);
        yd = qa(qm(yn, rad), ty);
        sx = ((xd * fx) >>> 20) + cx;
        sy = ((yd * fy) >>> 20) + cy;
        if (sx < 0) sx = 0;
        if (sx >= 639 * 256) sx = 638 * 256;
        if (sy < 0) sy = 0;
        if (sy >= 479 * 256) sy = 478 * 256;
    endfunction

    function byte unsigned blend(int px, int py);
        longint sx, sy, dx, dy, acc;
        int a;
        locate(px, py, sx, sy);
        dx = sx & 255;
        dy = sy & 255;
        a = int'(sy >>> 8) * 640 + int'(sx >>> 8);
        acc = (256 - dx) * (256 - dy) * frame_pix[a] + dx * (256 - dy) * frame_pix[a + 1]
            + (256 - dx) * dy * frame_pix[a + 640] + dx * dy * frame_pix[a + 641];
        return byte'((acc >> 16) & 255);
    endfunction

    function void note_word(logic func, int px, int py, byte unsigned pv);
        if (func == lur_pkg::FUNC_LOAD) begin
            if (px < 640 && py < 480) begin
                frame_pix[py * 640 + px] = pv;
                frame_valid[py * 640 + px] = 1'b1;
            end
        end else begin
            expected_pixels.insert(expected_pixels.size(), blend(px, py));
        end
    endfunction

    function void check_pixel(byte unsigned got);
        byte unsigned want;
        if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pixel %0d", got);
            return;
        end
        want = expected_pixels.pop_front();
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) $display("pixel mismatch: expected %0d got %0d", want, got);
        end
    endfunction
endclass

module tb_top;
    import lur_pkg::*;

    localparam int IDLE_LIMIT = 3000;   // cycles with no word moving on any channel
    localparam int DRAIN_WAIT = 60;     // pipeline depth plus margin

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_func;
    logic [9:0]            i_pos_x;
    logic [8:0]            i_pos_y;
    logic [7:0]            i_pixel_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_pixel_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    remap_scoreboard sb;
    int  idle_mode;        // 0: sender 16 / receiver 77, 1: swapped, 2: no idling
    int  words_sent;
    int  pixels_seen;
    int  quiet_cycles;
    bit  holdoff_done;

    lens_undistort_remap_core i_dut (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_func      <= FUNC_LOAD;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_pixel_in  <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_FOCAL_X;
        i_cfg_data  <= '0;
    end

    // Receiver: random stalls per idle mode, plus one long hold-off so the pipeline
    // fills and the input side backs up.
    always @(posedge i_clk) begin
        if (!holdoff_done && pixels_seen >= 20) begin
            holdoff_done = 1'b1;
            i_out_ready <= 1'b0;
            repeat (500) @(posedge i_clk);
        end
        case (idle_mode)
            0:       i_out_ready <= ($urandom_range(0, 99) >= 77);
            1:       i_out_ready <= ($urandom_range(0, 99) >= 16);
            default: i_out_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_pixel(o_pixel_out);
            pixels_seen++;
        end
    end

    // Watchdog on channel activity
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(logic func, int px, int py, int pv);
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == 0) ? 16 : (idle_mode == 1) ? 77 : 0;
        while ($urandom_range(0, 99) < pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_pos_x    <= px[9:0];
        i_pos_y    <= py[8:0];
        i_pixel_in <= pv[7:0];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(func, px, py, byte'(pv));
        words_sent++;
        idle_mode = (words_sent < 360) ? 0 : (words_sent < 720) ? 1 : 2;
    endtask

    // Loads any of the four neighbors not yet written, then asks for the pixel.
    task automatic sample_pixel(int px, int py);
        longint sx, sy;
        int a;
        sb.locate(px, py, sx, sy);
        a = int'(sy >>> 8) * 640 + int'(sx >>> 8);
        for (int k = 0; k < 4; k++) begin
            int off;
            off = (k == 0) ? 0 : (k == 1) ? 1 : (k == 2) ? 640 : 641;
            if (!sb.frame_valid[a + off])
                send_word(FUNC_LOAD, (a + off) % 640, (a + off) / 640, $urandom_range(0, 255));
        end
        send_word(FUNC_SAMPLE, px, py, $urandom_range(0, 255));
    endtask

    // Leaves valid high; the caller drops it after the last write.
    task automatic write_reg(t_cfg_idx idx, logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Full lens setting; upper data bits carry junk the core must drop (not in the principal word).
    task automatic write_lens(int fx, int fy, int cx, int cy,
                              int k1, int k2, int k3, int p1, int p2);
        logic [23:0] junk;
        junk = $urandom;
        write_reg(CFG_FOCAL_X,   {junk, 4'h0, fx[19:0]});
        write_reg(CFG_FOCAL_Y,   {junk, 4'h0, fy[19:0]});
        write_reg(CFG_PRINCIPAL, {cx[23:0], cy[23:0]});
        write_reg(CFG_K1,        {junk, k1[23:0]});
        write_reg(CFG_K2,        {junk, k2[23:0]});
        write_reg(CFG_K3,        {junk, k3[23:0]});
        write_reg(CFG_P1,        {junk, p1[23:0]});
        write_reg(CFG_P2,        {junk, p2[23:0]});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_words(int n);
        repeat (n) begin
            if ($urandom_range(0, 99) < 25)
                send_word(FUNC_LOAD, $urandom_range(0, 1023), $urandom_range(0, 511),
                          $urandom_range(0, 255));
            else
                sample_pixel($urandom_range(0, 1023), $urandom_range(0, 511));
        end
    endtask

    initial begin
        sb = new();
        idle_mode = 0;
        words_sent = 0;
        pixels_seen = 0;
        quiet_cycles = 0;
        holdoff_done = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: frame corners, extreme pixel values, loads outside the frame
        // (ignored), samples at and beyond the frame edge.
        send_word(FUNC_LOAD, 0, 0, 255);
        send_word(FUNC_LOAD, 639, 479, 0);
        send_word(FUNC_LOAD, 1023, 511, 170);
        send_word(FUNC_LOAD, 640, 0, 85);
        send_word(FUNC_LOAD, 0, 480, 85);
        sample_pixel(0, 0);
        sample_pixel(639, 479);
        sample_pixel(1023, 511);
        sample_pixel(320, 240);
        sample_pixel(682, 341);
        drain();

        // Realistic barrel lens centered on the frame
        write_lens(640 * 256, 600 * 256, 320 * 256, 240 * 256,
                   -314573, 104858, -10486, 1049, -2097);
        sample_pixel(0, 0);
        sample_pixel(639, 479);
        random_words(80);
        drain();

        // Extremes: zero focal, largest focal, centre at its top, coefficients at limits
        write_lens(0, 1048575, 24'hFFFFFF, 24'hFFFFFF,
                   8388607, -8388608, 8388607, -8388608, 8388607);
        sample_pixel(0, 0);
        sample_pixel(1023, 511);
        random_words(50);
        drain();

        // Shortest real focal length, all coefficients at their minimum
        write_lens(256, 256, 0, 0, -8388608, -8388608, -8388608, -8388608, -8388608);
        random_words(50);
        drain();

        // Random lens settings
        repeat (2) begin
            write_lens($urandom_range(256, 1048575), $urandom_range(256, 1048575),
                       $urandom_range(0, 640 * 256), $urandom_range(0, 480 * 256),
                       $urandom, $urandom, $urandom, $urandom, $urandom);
            random_words(50);
            drain();
        end

        // Back to the reset values
        write_lens(163840, 163840, 0, 0, 0, 0, 0, 0, 0);
        random_words(60);
        drain();

        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
design/lur_pkg.sv
design/lur_norm.sv
design/lur_warp.sv
design/lur_fetch.sv
design/lens_undistort_remap_core.sv
tb/tb_top.sv
